[rtl/core/ldrsm_pkg.sv]
package ldrsm_pkg;

    // Field widths fixed by the item format
    localparam int ACT_W      = 2;
    localparam int LAYER_FW   = 3;
    localparam int ETA_W      = 16;
    localparam int PHI_W      = 15;
    localparam int THR_W      = 15;
    localparam int THR_SQ_W   = 2 * THR_W;

    // Distance datapath widths
    localparam int DE_W       = ETA_W + 1;      // eta difference, signed
    localparam int DPHI_W     = PHI_W + 1;      // raw phi difference, signed
    localparam int TW_W       = 17;             // phi difference + 3*pi, always positive
    localparam int RW_W       = 15;             // remainder below 2*pi
    localparam int WR_W       = 16;             // wrapped phi, signed
    localparam int AE_W       = DE_W;           // |d_eta|
    localparam int AP_W       = 14;             // |d_phi| <= pi
    localparam int SQE_W      = 32;             // |d_eta|^2 stays below 2^32
    localparam int SQP_W      = 2 * AP_W;
    localparam int SUM_W      = SQE_W + 1;

    // Fixed point angles, 12 fractional bits
    localparam logic [TW_W-1:0] FX_PI       = 17'd12868;
    localparam logic [TW_W-1:0] FX_TWO_PI   = 17'd25736;
    localparam logic [TW_W-1:0] FX_FOUR_PI  = 17'd51472;
    localparam logic [TW_W-1:0] FX_THREE_PI = 17'd38604;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;

    localparam logic [THR_W-1:0]    DR_THRESHOLD_RESET = 15'd410;
    localparam logic [THR_SQ_W-1:0] DR_THR_SQ_RESET    = 30'd168100;

    localparam int MAX_SEEDS_DEF  = 16;
    localparam int NUM_LAYERS_DEF = 4;

    typedef struct packed {
        logic busy;   // a seed is still in the distance pipeline
        logic hit;    // the seed leaving the pipeline lies inside the cone
    } dist_status_t;

endpackage

[rtl/core/ldrsm_ram.sv]
module ldrsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ldrsm_dist.sv]
module ldrsm_dist (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               seed_valid,
    input  logic [ldrsm_pkg::ETA_W-1:0]        seed_eta,
    input  logic [ldrsm_pkg::PHI_W-1:0]        seed_phi,
    input  logic [ldrsm_pkg::ETA_W-1:0]        cell_eta,
    input  logic [ldrsm_pkg::PHI_W-1:0]        cell_phi,
    input  logic [ldrsm_pkg::THR_SQ_W-1:0]     thr_sq,
    output ldrsm_pkg::dist_status_t            status
);

    // Difference stage
    logic                              diff_valid_reg;
    logic [ldrsm_pkg::DE_W-1:0]        de_reg, de_next;
    logic [ldrsm_pkg::TW_W-1:0]        tw_reg, tw_next;
    logic [ldrsm_pkg::DPHI_W-1:0]      dphi;
    logic [ldrsm_pkg::TW_W:0]          tw_full;

    // Magnitude stage
    logic                              abs_valid_reg;
    logic [ldrsm_pkg::AE_W-1:0]        ae_reg, ae_next;
    logic [ldrsm_pkg::AP_W-1:0]        ap_reg, ap_next;
    logic [ldrsm_pkg::TW_W-1:0]        rem_full;
    logic [ldrsm_pkg::WR_W-1:0]        wrapped;
    logic [ldrsm_pkg::WR_W-1:0]        wrapped_abs;

    // Square stage
    logic                              sq_valid_reg;
    logic [ldrsm_pkg::SQE_W-1:0]       sq_e_reg, sq_e_next;
    logic [ldrsm_pkg::SQP_W-1:0]       sq_p_reg, sq_p_next;
    logic [2*ldrsm_pkg::AE_W-1:0]      sq_e_full;
    logic [ldrsm_pkg::SUM_W-1:0]       dist_sum;

    always_comb
    begin
        de_next = {seed_eta[ldrsm_pkg::ETA_W-1], seed_eta}
                - {cell_eta[ldrsm_pkg::ETA_W-1], cell_eta};
        dphi    = {seed_phi[ldrsm_pkg::PHI_W-1], seed_phi}
                - {cell_phi[ldrsm_pkg::PHI_W-1], cell_phi};
        // shift by 3*pi so the modulo sees a positive value
        tw_full = {{2{dphi[ldrsm_pkg::DPHI_W-1]}}, dphi} + {1'b0, ldrsm_pkg::FX_THREE_PI};
        tw_next = tw_full[ldrsm_pkg::TW_W-1:0];
    end

    always_comb
    begin
        ae_next = de_reg[ldrsm_pkg::DE_W-1] ? (~de_reg + 1'b1) : de_reg;

        // value is below three times 2*pi: at most two subtractions
        if (tw_reg >= ldrsm_pkg::FX_FOUR_PI)
        begin
            rem_full = tw_reg - ldrsm_pkg::FX_FOUR_PI;
        end
        else if (tw_reg >= ldrsm_pkg::FX_TWO_PI)
        begin
            rem_full = tw_reg - ldrsm_pkg::FX_TWO_PI;
        end
        else
        begin
            rem_full = tw_reg;
        end
        wrapped     = {1'b0, rem_full[ldrsm_pkg::RW_W-1:0]}
                    - ldrsm_pkg::FX_PI[ldrsm_pkg::WR_W-1:0];
        wrapped_abs = wrapped[ldrsm_pkg::WR_W-1] ? (~wrapped + 1'b1) : wrapped;
        ap_next     = wrapped_abs[ldrsm_pkg::AP_W-1:0];
    end

    always_comb
    begin
        sq_e_full = ae_reg * ae_reg;
        sq_e_next = sq_e_full[ldrsm_pkg::SQE_W-1:0];
        sq_p_next = ap_reg * ap_reg;
        dist_sum  = {1'b0, sq_e_reg} + ldrsm_pkg::SUM_W'(sq_p_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            abs_valid_reg  <= 1'b0;
            sq_valid_reg   <= 1'b0;
        end
        else
        begin
            diff_valid_reg <= seed_valid;
            abs_valid_reg  <= diff_valid_reg;
            sq_valid_reg   <= abs_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        de_reg   <= de_next;
        tw_reg   <= tw_next;
        ae_reg   <= ae_next;
        ap_reg   <= ap_next;
        sq_e_reg <= sq_e_next;
        sq_p_reg <= sq_p_next;
    end

    assign status.busy = diff_valid_reg | abs_valid_reg | sq_valid_reg;
    assign status.hit  = sq_valid_reg && (dist_sum < ldrsm_pkg::SUM_W'(thr_sq));

endmodule

[rtl/core/layered_delta_r_seed_match_core.sv]
// Seed cone matcher: holds up to MAX_SEEDS (eta, phi) seeds for each of NUM_LAYERS layers and
// answers one beat per input beat. Clear, load and a test of an empty or invalid layer go
// straight to the finish step, which puts their result beat in the output register; the next
// item is taken once the block is back in idle. A test walks the n seeds of its layer one per
// cycle through the single read port of the seed store into the distance pipeline
// (difference, phi wrap and magnitude, squares, compare), waits in the drain step until the
// pipeline is empty, then finishes. The block takes one item at a time; item_stall stays
// high until the result beat is in the output register, so a stalled result beat holds the
// block in its last step. The user must make sure dr_threshold is written through the cfg
// channel only while the block is idle; the block itself does not enforce it. Its square is
// registered. Seed values are not cleared: a clear only zeroes the per-layer counts.
module layered_delta_r_seed_match_core #(
    parameter int MAX_SEEDS  = ldrsm_pkg::MAX_SEEDS_DEF,
    parameter int NUM_LAYERS = ldrsm_pkg::NUM_LAYERS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [ldrsm_pkg::ACT_W-1:0]        action,
    input  logic [ldrsm_pkg::LAYER_FW-1:0]     layer,
    input  logic signed [ldrsm_pkg::ETA_W-1:0] eta_value,
    input  logic signed [ldrsm_pkg::PHI_W-1:0] phi_value,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               keep,
    output logic                               overflow,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ldrsm_pkg::THR_W-1:0]        dr_threshold
);

    localparam int DEPTH   = NUM_LAYERS * MAX_SEEDS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(MAX_SEEDS + 1);
    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 seed_count_reg [NUM_LAYERS];
    logic [CNT_W-1:0]                 seed_count_next [NUM_LAYERS];
    logic [LAYER_W-1:0]               scan_layer_reg, scan_layer_next;
    logic [CNT_W-1:0]                 scan_k_reg, scan_k_next;
    logic [CNT_W-1:0]                 scan_n_reg, scan_n_next;
    logic [ldrsm_pkg::ETA_W-1:0]      cell_eta_reg, cell_eta_next;
    logic [ldrsm_pkg::PHI_W-1:0]      cell_phi_reg, cell_phi_next;
    logic                             hit_reg, hit_next;
    logic                             res_keep_reg, res_keep_next;
    logic                             res_ovf_reg, res_ovf_next;
    logic                             result_valid_reg, result_valid_next;
    logic                             keep_reg, keep_next;
    logic                             overflow_reg, overflow_next;
    logic                             rd_valid_reg;
    logic [ldrsm_pkg::THR_W-1:0]      thr_reg;
    logic [ldrsm_pkg::THR_SQ_W-1:0]   thr_sq_reg;

    logic                             item_accept;
    logic                             layer_ok;
    logic [LAYER_W-1:0]               layer_idx;
    logic [CNT_W-1:0]                 cur_n;
    logic                             ram_we;
    logic [LAYER_W-1:0]               addr_layer;
    logic [CNT_W-1:0]                 addr_off;
    logic [ADDR_W-1:0]                ram_addr;
    logic [ldrsm_pkg::ETA_W-1:0]      eta_rd;
    logic [ldrsm_pkg::PHI_W-1:0]      phi_rd;
    ldrsm_pkg::dist_status_t          dist_status;

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    assign layer_ok  = ({1'b0, layer} < 4'(NUM_LAYERS));
    assign layer_idx = layer[LAYER_W-1:0];
    assign cur_n     = layer_ok ? seed_count_reg[layer_idx] : '0;

    assign ram_we     = item_accept && (action == ldrsm_pkg::ACT_LOAD) && layer_ok
                     && (cur_n < CNT_W'(MAX_SEEDS));
    assign addr_layer = (state_reg == ST_IDLE) ? layer_idx : scan_layer_reg;
    assign addr_off   = (state_reg == ST_IDLE) ? cur_n : scan_k_reg;
    assign ram_addr   = ADDR_W'(ADDR_W'(addr_layer) * ADDR_W'(MAX_SEEDS)) + ADDR_W'(addr_off);

    ldrsm_ram #(
        .WIDTH (ldrsm_pkg::ETA_W),
        .DEPTH (DEPTH)
    ) u_eta_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (eta_value),
        .rdata (eta_rd)
    );

    ldrsm_ram #(
        .WIDTH (ldrsm_pkg::PHI_W),
        .DEPTH (DEPTH)
    ) u_phi_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (phi_value),
        .rdata (phi_rd)
    );

    ldrsm_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_valid (rd_valid_reg),
        .seed_eta   (eta_rd),
        .seed_phi   (phi_rd),
        .cell_eta   (cell_eta_reg),
        .cell_phi   (cell_phi_reg),
        .thr_sq     (thr_sq_reg),
        .status     (dist_status)
    );

    always_comb
    begin
        state_next        = state_reg;
        seed_count_next   = seed_count_reg;
        scan_layer_next   = scan_layer_reg;
        scan_k_next       = scan_k_reg;
        scan_n_next       = scan_n_reg;
        cell_eta_next     = cell_eta_reg;
        cell_phi_next     = cell_phi_reg;
        hit_next          = hit_reg | dist_status.hit;
        res_keep_next     = res_keep_reg;
        res_ovf_next      = res_ovf_reg;
        result_valid_next = result_valid_reg;
        keep_next         = keep_reg;
        overflow_next     = overflow_reg;

        // drop the output beat once taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    cell_eta_next = eta_value;
                    cell_phi_next = phi_value;
                    hit_next      = 1'b0;
                    res_keep_next = 1'b0;
                    res_ovf_next  = 1'b0;
                    state_next    = ST_FINISH;
                    case (action)
                        ldrsm_pkg::ACT_CLEAR:
                        begin
                            for (int i = 0; i < NUM_LAYERS; i++)
                            begin
                                seed_count_next[i] = '0;
                            end
                        end
                        ldrsm_pkg::ACT_LOAD:
                        begin
                            if (layer_ok)
                            begin
                                if (cur_n >= CNT_W'(MAX_SEEDS))
                                begin
                                    res_ovf_next = 1'b1;
                                end
                                else
                                begin
                                    seed_count_next[layer_idx] = CNT_W'(cur_n + 1'b1);
                                end
                            end
                        end
                        ldrsm_pkg::ACT_TEST:
                        begin
                            if (layer_ok && (cur_n != '0))
                            begin
                                scan_layer_next = layer_idx;
                                scan_k_next     = '0;
                                scan_n_next     = cur_n;
                                state_next      = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one seed read issued per cycle
                scan_k_next = CNT_W'(scan_k_reg + 1'b1);
                if (CNT_W'(scan_k_reg + 1'b1) == scan_n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !dist_status.busy)
                begin
                    res_keep_next = hit_reg;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    keep_next         = res_keep_reg;
                    overflow_next     = res_ovf_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            for (int i = 0; i < NUM_LAYERS; i++)
            begin
                seed_count_reg[i] <= '0;
            end
            scan_k_reg       <= '0;
            scan_n_reg       <= '0;
            hit_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            rd_valid_reg     <= 1'b0;
            thr_reg          <= ldrsm_pkg::DR_THRESHOLD_RESET;
            thr_sq_reg       <= ldrsm_pkg::DR_THR_SQ_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            seed_count_reg   <= seed_count_next;
            scan_k_reg       <= scan_k_next;
            scan_n_reg       <= scan_n_next;
            hit_reg          <= hit_next;
            result_valid_reg <= result_valid_next;
            rd_valid_reg     <= (state_reg == ST_SCAN);
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= dr_threshold;
            end
            thr_sq_reg       <= thr_reg * thr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_layer_reg <= scan_layer_next;
        cell_eta_reg   <= cell_eta_next;
        cell_phi_reg   <= cell_phi_next;
        res_keep_reg   <= res_keep_next;
        res_ovf_reg    <= res_ovf_next;
        keep_reg       <= keep_next;
        overflow_reg   <= overflow_next;
    end

    assign result_valid = result_valid_reg;
    assign keep         = keep_reg;
    assign overflow     = overflow_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_k_reg < scan_n_reg))
        else $error("seed scan index ran past the layer count");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result beat raised outside the finish step");

    a_keep_ovf_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(keep_reg && overflow_reg))
        else $error("keep and overflow both set in one result");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_valid_reg && !dist_status.busy))
        else $error("distance pipeline busy while idle");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (action == ldrsm_pkg::ACT_CLEAR)) |=> (seed_count_reg[0] == '0))
        else $error("seed count not cleared");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int SEEDS_PER_LAYER = ldrsm_pkg::MAX_SEEDS_DEF;
    localparam int LAYER_COUNT     = ldrsm_pkg::NUM_LAYERS_DEF;
    localparam int PI_FX           = int'(ldrsm_pkg::FX_PI);
    localparam int TWO_PI_FX       = int'(ldrsm_pkg::FX_TWO_PI);
    localparam int ETA_MIN         = -(1 << (ldrsm_pkg::ETA_W - 1));
    localparam int ETA_MAX         = (1 << (ldrsm_pkg::ETA_W - 1)) - 1;
    localparam int PHI_MIN         = -(1 << (ldrsm_pkg::PHI_W - 1));
    localparam int PHI_MAX         = (1 << (ldrsm_pkg::PHI_W - 1)) - 1;
    localparam logic [ldrsm_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int LONG_HOLD       = 150;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct packed {
        logic keep;
        logic overflow;
    } cone_result_t;

    class cone_scoreboard;
        int unsigned  radius;
        int           seed_eta[LAYER_COUNT][SEEDS_PER_LAYER];
        int           seed_phi[LAYER_COUNT][SEEDS_PER_LAYER];
        int unsigned  seed_cnt[LAYER_COUNT];
        cone_result_t expected_q[$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  kept;
        int unsigned  overflowed;

        function new();
            radius = 32'(ldrsm_pkg::DR_THRESHOLD_RESET);
            foreach (seed_cnt[i]) seed_cnt[i] = 0;
            errors = 0;
            checked = 0;
            kept = 0;
            overflowed = 0;
        endfunction

        function void set_radius(logic [ldrsm_pkg::THR_W-1:0] value);
            radius = 32'(value);
        endfunction

        // true modulo: any difference lands in [-pi, pi)
        function int wrap_phi(int d);
            int r;
            r = (d + 3 * PI_FX) % TWO_PI_FX;
            if (r < 0) r += TWO_PI_FX;
            return r - PI_FX;
        endfunction

        function bit cone_hit(int lyr, int eta, int phi);
            longint lim;
            longint de;
            longint dp;
            bit hit;
            lim = longint'(radius) * longint'(radius);
            hit = 1'b0;
            for (int k = 0; k < int'(seed_cnt[lyr]); k++) begin
                de = longint'(seed_eta[lyr][k]) - longint'(eta);
                dp = longint'(wrap_phi(seed_phi[lyr][k] - phi));
                if (de * de + dp * dp < lim) hit = 1'b1;
            end
            return hit;
        endfunction

        function void note_item(logic [ldrsm_pkg::ACT_W-1:0] act,
                                logic [ldrsm_pkg::LAYER_FW-1:0] lyr,
                                logic signed [ldrsm_pkg::ETA_W-1:0] eta,
                                logic signed [ldrsm_pkg::PHI_W-1:0] phi);
            cone_result_t res;
            int li;
            res = '0;
            li = int'(lyr);
            case (act)
                ldrsm_pkg::ACT_CLEAR: foreach (seed_cnt[i]) seed_cnt[i] = 0;
                ldrsm_pkg::ACT_LOAD:
                    if (li < LAYER_COUNT) begin
                        if (seed_cnt[li] >= SEEDS_PER_LAYER) begin
                            res.overflow = 1'b1;
                        end
                        else begin
                            seed_eta[li][seed_cnt[li]] = int'(eta);
                            seed_phi[li][seed_cnt[li]] = int'(phi);
                            seed_cnt[li]++;
                        end
                    end
                ldrsm_pkg::ACT_TEST:
                    if (li < LAYER_COUNT) res.keep = cone_hit(li, int'(eta), int'(phi));
                default: ;
            endcase
            expected_q = {expected_q, res};
        endfunction

        function void check_beat(logic k, logic ov);
            cone_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing outstanding, actual keep %0b overflow %0b",
                         $time, k, ov);
            end
            else begin
                want = expected_q.pop_front();
                checked++;
                if (want.keep) kept++;
                if (want.overflow) overflowed++;
                if (want.keep !== k) begin
                    errors++;
                    $display("%0t: keep mismatch, expected %0b actual %0b",
                             $time, want.keep, k);
                end
                if (want.overflow !== ov) begin
                    errors++;
                    $display("%0t: overflow mismatch, expected %0b actual %0b",
                             $time, want.overflow, ov);
                end
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function bit pick_seed(int lyr, output int eta, output int phi);
            int k;
            eta = 0;
            phi = 0;
            if (lyr >= LAYER_COUNT || seed_cnt[lyr] == 0) return 1'b0;
            k = $urandom_range(0, seed_cnt[lyr] - 1);
            eta = seed_eta[lyr][k];
            phi = seed_phi[lyr][k];
            return 1'b1;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                                item_valid;
    logic                                item_stall;
    logic [ldrsm_pkg::ACT_W-1:0]         action;
    logic [ldrsm_pkg::LAYER_FW-1:0]      layer;
    logic signed [ldrsm_pkg::ETA_W-1:0]  eta_value;
    logic signed [ldrsm_pkg::PHI_W-1:0]  phi_value;
    logic                                result_valid;
    logic                                result_stall;
    logic                                keep;
    logic                                overflow;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [ldrsm_pkg::THR_W-1:0]         dr_threshold;

    cone_scoreboard sb;
    bit             src_gaps;
    bit             sink_gaps;
    int             long_hold;
    int unsigned    items_in;
    int unsigned    radius_writes;
    int unsigned    quiet_cycles;

    layered_delta_r_seed_match_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .layer        (layer),
        .eta_value    (eta_value),
        .phi_value    (phi_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .keep         (keep),
        .overflow     (overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .dr_threshold (dr_threshold)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sample every handshake at the rising edge; watchdog on lack of progress
    always @(posedge clk)
    begin
        if (rst_n) begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready) begin
                sb.set_radius(dr_threshold);
                radius_writes++;
                quiet_cycles = 0;
            end
            if (item_valid && !item_stall) begin
                sb.note_item(action, layer, eta_value, phi_value);
                items_in++;
                quiet_cycles = 0;
            end
            if (result_valid && !result_stall) begin
                sb.check_beat(keep, overflow);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: draw a stall per beat, or hold off for a long stretch on request
    initial
    begin
        int wait_cycles;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold > 0) begin
                wait_cycles = long_hold;
                long_hold = 0;
            end
            else begin
                wait_cycles = sink_gaps ? $urandom_range(0, 6) : 0;
            end
            if (wait_cycles > 0) begin
                result_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!(result_valid && !result_stall)) @(posedge clk);
        end
    end

    function automatic int clamp_to(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int rand_eta();
        return int'($urandom_range(0, 65535)) + ETA_MIN;
    endfunction

    function automatic int rand_phi();
        return int'($urandom_range(0, 32767)) + PHI_MIN;
    endfunction

    function automatic logic [ldrsm_pkg::LAYER_FW-1:0] rand_layer();
        int v;
        v = $urandom_range(0, 7);
        return v[ldrsm_pkg::LAYER_FW-1:0];
    endfunction

    function automatic int seed_eta_pick();
        if ($urandom_range(0, 7) == 0) return rand_eta();
        return int'($urandom_range(0, 48000)) - 24000;
    endfunction

    // favor seeds near +/-pi so the wrap gets exercised
    function automatic int seed_phi_pick();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return rand_phi();
        if (r < 3) return ($urandom_range(0, 1) ? PI_FX : -PI_FX)
                          + int'($urandom_range(0, 800)) - 400;
        return int'($urandom_range(0, 2 * PI_FX)) - PI_FX;
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_item(input logic [ldrsm_pkg::ACT_W-1:0] a,
                             input logic [ldrsm_pkg::LAYER_FW-1:0] l,
                             input int e, input int p);
        int gap;
        gap = src_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action     <= a;
        layer      <= l;
        eta_value  <= e[ldrsm_pkg::ETA_W-1:0];
        phi_value  <= p[ldrsm_pkg::PHI_W-1:0];
        item_valid <= 1'b1;
        @(posedge clk);
        while (!(item_valid && !item_stall)) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
    endtask

    task automatic write_radius(input logic [ldrsm_pkg::THR_W-1:0] value);
        cfg_valid    <= 1'b1;
        dr_threshold <= value;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready)) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // test a cell placed around a stored seed, just inside or outside the cone
    task automatic send_near_test(input int lyr);
        int se;
        int sp;
        int span;
        int e;
        int p;
        if (!sb.pick_seed(lyr, se, sp)) begin
            send_item(ldrsm_pkg::ACT_TEST, lyr[ldrsm_pkg::LAYER_FW-1:0], rand_eta(), rand_phi());
        end
        else begin
            span = int'(sb.radius) + int'(sb.radius) / 4 + 8;
            e = se + int'($urandom_range(0, 2 * span)) - span;
            p = sp + int'($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 4) == 0) p += $urandom_range(0, 1) ? TWO_PI_FX : -TWO_PI_FX;
            send_item(ldrsm_pkg::ACT_TEST, lyr[ldrsm_pkg::LAYER_FW-1:0],
                      clamp_to(e, ETA_MIN, ETA_MAX), clamp_to(p, PHI_MIN, PHI_MAX));
        end
    endtask

    task automatic run_episode();
        int focus;
        int n_loads;
        int n_tests;
        int lyr;
        int pick;
        int v;
        focus = $urandom_range(0, LAYER_COUNT - 1);
        if ($urandom_range(0, 3) != 0) begin
            send_item(ldrsm_pkg::ACT_CLEAR, rand_layer(), rand_eta(), rand_phi());
        end
        // loads pile onto one layer so full lists come up often
        n_loads = $urandom_range(0, 22);
        for (int i = 0; i < n_loads; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) lyr = focus;
            else if (pick < 9) lyr = $urandom_range(0, LAYER_COUNT - 1);
            else lyr = $urandom_range(LAYER_COUNT, 7);
            send_item(ldrsm_pkg::ACT_LOAD, lyr[ldrsm_pkg::LAYER_FW-1:0], seed_eta_pick(),
                      seed_phi_pick());
        end
        n_tests = $urandom_range(4, 16);
        for (int i = 0; i < n_tests; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                send_near_test(focus);
            end
            else if (pick < 6) begin
                send_near_test($urandom_range(0, LAYER_COUNT - 1));
            end
            else if (pick < 8) begin
                send_item(ldrsm_pkg::ACT_TEST, rand_layer(), rand_eta(), rand_phi());
            end
            else begin
                v = $urandom_range(0, 3);
                send_item(v[ldrsm_pkg::ACT_W-1:0], rand_layer(), rand_eta(), rand_phi());
            end
        end
    endtask

    initial
    begin
        int phase_start;
        logic [ldrsm_pkg::THR_W-1:0] next_radius;
        sb            = new;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        action        = ldrsm_pkg::ACT_CLEAR;
        layer         = '0;
        eta_value     = '0;
        phi_value     = '0;
        cfg_valid     = 1'b0;
        dr_threshold  = ldrsm_pkg::DR_THRESHOLD_RESET;
        src_gaps      = 1'b1;
        sink_gaps     = 1'b1;
        long_hold     = 0;
        items_in      = 0;
        radius_writes = 0;
        quiet_cycles  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty layer, spare code, cone edge, phi wrap, field extremes,
        // invalid layers, clear leaving stale values unread
        send_item(ldrsm_pkg::ACT_TEST,  3'd0, 0, 0);
        send_item(ACT_SPARE,            3'd2, 100, 100);
        send_item(ldrsm_pkg::ACT_LOAD,  3'd0, 0, 0);
        send_item(ldrsm_pkg::ACT_TEST,  3'd0, 0, 0);
        send_item(ldrsm_pkg::ACT_TEST,  3'd0, 409, 0);
        send_item(ldrsm_pkg::ACT_TEST,  3'd0, 410, 0);
        send_item(ldrsm_pkg::ACT_TEST,  3'd0, 0, -410);
        send_item(ldrsm_pkg::ACT_TEST,  3'd0, 290, 289);
        send_item(ldrsm_pkg::ACT_LOAD,  3'd1, 0, PI_FX);
        send_item(ldrsm_pkg::ACT_TEST,  3'd1, 0, -PI_FX);
        send_item(ldrsm_pkg::ACT_LOAD,  3'd2, ETA_MIN, PHI_MAX);
        send_item(ldrsm_pkg::ACT_TEST,  3'd2, ETA_MAX, PHI_MIN);
        send_item(ldrsm_pkg::ACT_TEST,  3'd2, ETA_MIN, PHI_MAX);
        send_item(ldrsm_pkg::ACT_TEST,  3'd2, ETA_MIN + 100, PHI_MIN);
        send_item(ldrsm_pkg::ACT_LOAD,  3'd4, 0, 0);
        send_item(ldrsm_pkg::ACT_LOAD,  3'd7, -1, -1);
        send_item(ldrsm_pkg::ACT_TEST,  3'd5, 0, 0);
        send_item(ldrsm_pkg::ACT_TEST,  3'd3, ETA_MAX, 0);
        send_item(ldrsm_pkg::ACT_CLEAR, 3'd7, -1, -1);
        send_item(ldrsm_pkg::ACT_TEST,  3'd0, 0, 0);
        send_item(ACT_SPARE,            3'd7, -1, -1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph)
                1: next_radius = '0;
                2: next_radius = '1;
                3: next_radius = ldrsm_pkg::THR_W'($urandom_range(64, 3000));
                4: next_radius = 15'd1;
                5: next_radius = 15'd12000;
                6: next_radius = ldrsm_pkg::DR_THRESHOLD_RESET;
                default: next_radius = ldrsm_pkg::DR_THRESHOLD_RESET;
            endcase
            if (ph != 0) write_radius(next_radius);
            src_gaps  = (ph != 1 && ph != 3);
            sink_gaps = (ph != 1 && ph != 2);
            // starve the result side so the block backs up into its input
            if (ph == 3) long_hold = LONG_HOLD;
            phase_start = items_in;
            while (items_in - phase_start < ITEMS_PER_PHASE) run_episode();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Ran %0d items and %0d radius writes through %0d phases, 0 to full scale.",
                 items_in, radius_writes, NUM_PHASES);
        $display("Checked %0d results: %0d cells kept, %0d loads overflowed.",
                 sb.checked, sb.kept, sb.overflowed);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("No mismatches found");
        end
        else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
